// ===== rtl/texel_format_converter_core_macros.svh =====
// Assertion macros for the texel format converter core.
// Included by the checker module; no other dependencies.
`ifndef TEXEL_FORMAT_CONVERTER_CORE_MACROS_SVH
`define TEXEL_FORMAT_CONVERTER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define TFC_ASSERT_RUN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TFC_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tfc_pkg.sv =====
// Shared types and constants for the texel format converter core.
// No dependencies; imported by every RTL module of the block.
package tfc_pkg;

    localparam int unsigned TEXEL_W         = 16;
    localparam int unsigned MODE_W          = 3;
    localparam int unsigned SRC_W           = 32;
    localparam int unsigned TFC_QUEUE_DEPTH = 4;

    // Source format selector
    localparam logic [MODE_W-1:0] MODE_RGBA16 = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RGBA32 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IA4    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IA8    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_IA16   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_I4     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_I8     = 3'd6;

    // One converted source unit: one or two finished texels
    typedef struct packed {
        logic [TEXEL_W-1:0] texel0;
        logic [TEXEL_W-1:0] texel1;
        logic               pair;
        logic               final_req;
    } tfc_entry_t;

    typedef struct packed {
        logic       valid;
        tfc_entry_t entry;
    } tfc_push_t;

    typedef struct packed {
        logic       valid;
        tfc_entry_t entry;
    } tfc_head_t;

endpackage

// ===== rtl/tfc_front.sv =====
// Front end: accepts source units and converts them into finished texels.
// Depends on tfc_pkg; feeds tfc_fifo.
module tfc_front
    import tfc_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [SRC_W-1:0]  s_tdata,
    input  logic [MODE_W-1:0] s_tuser,
    input  logic              s_tlast,
    input  logic              full,
    output tfc_push_t         push
);

    // Alpha on top, intensity copied into blue, green and red
    function automatic logic [TEXEL_W-1:0] grey5(input logic [4:0] i5, input logic a);
        return {a, i5, i5, i5};
    endfunction

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;

    assign b0 = s_tdata[7:0];
    assign b1 = s_tdata[15:8];
    assign b2 = s_tdata[23:16];
    assign b3 = s_tdata[31:24];

    assign s_tready = !full;

    always_comb begin
        push.valid           = s_tvalid;
        push.entry.texel0    = '0;
        push.entry.texel1    = '0;
        push.entry.pair      = 1'b0;
        push.entry.final_req = s_tlast;
        unique case (s_tuser)
            MODE_RGBA16: begin
                // R5 G5 B5 A1 from the top bit of byte0 down
                push.entry.texel0 = {b1[0], b1[5:1], b0[2:0], b1[7:6], b0[7:3]};
            end
            MODE_RGBA32: begin
                push.entry.texel0 = {b3[7], b2[7:3], b1[7:3], b0[7:3]};
            end
            MODE_IA4: begin
                push.entry.texel0 = grey5({b0[7:5], b0[7:6]}, b0[4]);
                push.entry.texel1 = grey5({b0[3:1], b0[3:2]}, b0[0]);
                push.entry.pair   = 1'b1;
            end
            MODE_IA8: begin
                push.entry.texel0 = grey5({b0[7:4], b0[7]}, b0[3]);
            end
            MODE_IA16: begin
                push.entry.texel0 = grey5(b0[7:3], b1[7]);
            end
            MODE_I4: begin
                push.entry.texel0 = grey5({b0[7:4], b0[7]}, b0[7]);
                push.entry.texel1 = grey5({b0[3:0], b0[3]}, b0[3]);
                push.entry.pair   = 1'b1;
            end
            MODE_I8: begin
                push.entry.texel0 = grey5(b0[7:3], b0[7]);
            end
            default: begin
                // unused selector: a single blank texel keeps the frame end
                push.entry.texel0 = '0;
            end
        endcase
    end

endmodule

// ===== rtl/tfc_fifo.sv =====
// Short queue between front and back end of the texel format converter.
// Depends on tfc_pkg; instantiated by the top level.
module tfc_fifo
    import tfc_pkg::*;
#(
    parameter int unsigned DEPTH = TFC_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  tfc_push_t push,
    output logic      full,
    output tfc_head_t head,
    input  logic      pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tfc_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];
    assign push_fire  = push.valid && !full;
    assign pop_fire   = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== rtl/tfc_back.sv =====
// Back end: walks the queue head out as one texel per result item.
// Depends on tfc_pkg; drains tfc_fifo into the output register.
module tfc_back
    import tfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  tfc_head_t          head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TEXEL_W-1:0] m_tdata,
    output logic [0:0]         m_tuser,
    output logic               m_tlast
);

    logic               m_valid_reg;
    logic               m_valid_next;
    logic [TEXEL_W-1:0] texel_reg;
    logic [TEXEL_W-1:0] texel_next;
    logic               unit_last_reg;
    logic               unit_last_next;
    logic               image_end_reg;
    logic               image_end_next;
    logic               phase_reg;
    logic               phase_next;
    logic               load;

    assign load = head.valid && (!m_valid_reg || m_tready);

    always_comb begin
        m_valid_next   = m_valid_reg;
        texel_next     = texel_reg;
        unit_last_next = unit_last_reg;
        image_end_next = image_end_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        if (load) begin
            m_valid_next = 1'b1;
            if (phase_reg) begin
                // second texel of a 4-bit unit: retire the entry
                texel_next     = head.entry.texel1;
                unit_last_next = 1'b1;
                image_end_next = head.entry.final_req;
                pop            = 1'b1;
                phase_next     = 1'b0;
            end else begin
                texel_next     = head.entry.texel0;
                unit_last_next = !head.entry.pair;
                image_end_next = head.entry.final_req && !head.entry.pair;
                pop            = !head.entry.pair;
                phase_next     = head.entry.pair;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        texel_reg     <= texel_next;
        unit_last_reg <= unit_last_next;
        image_end_reg <= image_end_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = texel_reg;
    assign m_tuser[0] = unit_last_reg;
    assign m_tlast    = image_end_reg;

endmodule

// ===== rtl/texel_format_converter_core.sv =====
// Top level of the texel format converter: front end, queue and back end.
// Depends on tfc_pkg, tfc_front, tfc_fifo and tfc_back.
//
// Converts a stream of source texel units (rgba16, rgba32, ia4, ia8, ia16,
// i4, i8) into 16-bit texels with alpha in bit 15, blue in 14:10, green in
// 9:5 and red in 4:0. Intensity formats widen a 3- or 4-bit intensity to
// 5 bits by repeating its top bits, keep the top 5 of an 8-bit one, and
// copy it to all color channels. One texel per source unit, but ia4 and
// i4 give two per byte, high nibble first. Selector 7 gives one zero texel.
// Rate: the output port carries one texel per cycle while m_tready is high, so
// one-texel formats sustain one item per cycle and the 4-bit formats give two
// texels per item; the single result port of the back end sets that rate. An
// accepted item is converted combinationally, written into the queue and then
// loaded into the output register. The queue of DEPTH entries lets input keep
// flowing while a result waits on m_tready, until the queue fills.
// m_tuser[0] flags the last texel of a source unit; m_tlast flags the last
// texel of the image and is only set together with m_tuser[0].
module texel_format_converter_core
    import tfc_pkg::*;
#(
    parameter int unsigned DEPTH = TFC_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    // source units
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SRC_W-1:0]   s_tdata,   // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24]
    input  logic [MODE_W-1:0]  s_tuser,   // mode [2:0]
    input  logic               s_tlast,   // final_req: last source unit of the image
    // converted texels
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TEXEL_W-1:0] m_tdata,   // texel [15:0]
    output logic [0:0]         m_tuser,   // last_of_unit [0]
    output logic               m_tlast    // image_end: very last texel of the image
);

    tfc_push_t q_push;
    tfc_head_t q_head;
    logic      q_full;
    logic      q_pop;

    // Convert and classify each accepted unit; hold off when the queue fills
    tfc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .full     (q_full),
        .push     (q_push)
    );

    // Decouple acceptance from result delivery
    tfc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .full    (q_full),
        .head    (q_head),
        .pop     (q_pop)
    );

    // Emit one texel per cycle while m_tready is high; advance the queue on a unit's last texel
    tfc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/tfc_checker.sv =====
// Port-level checks for the texel format converter core, bound to the top.
// Depends on tfc_pkg and texel_format_converter_core_macros.svh.
`include "texel_format_converter_core_macros.svh"

module tfc_checker
    import tfc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TEXEL_W-1:0] m_tdata,
    input logic [0:0]         m_tuser,
    input logic               m_tlast
);

    // A stalled result holds its value
    `TFC_ASSERT_RUN(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled texel changed")

    // Reset empties the output register
    `TFC_ASSERT_ALL(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // Image end only on the last texel of a unit
    `TFC_ASSERT_RUN(a_end_on_last, aclk, aresetn, m_tvalid && m_tlast |-> m_tuser[0], "image end without unit end")

    // The second texel of a pair follows right after the first
    `TFC_ASSERT_RUN(a_pair_follows, aclk, aresetn, m_tvalid && m_tready && !m_tuser[0] |=> m_tvalid, "second texel of pair missing")

endmodule

bind texel_format_converter_core tfc_checker u_tfc_checker (.*);

// ===== test/texel_format_converter_core_tb.sv =====
// Self-checking testbench for texel_format_converter_core: directed table, then random units.
// Depends on tfc_pkg and the texel_format_converter_core RTL; needs no files at run time.
module texel_format_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;  // selector with no format
    localparam int RANDOM_UNITS = 1300;
    localparam int STALL_LIMIT  = 1000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 10;

    // One expected texel as it leaves the master side
    typedef struct packed {
        logic [TEXEL_W-1:0] texel;
        logic               last_of_unit;
        logic               image_end;
    } texel_result_t;

    // One directed source unit; fixed_cnt > 0 means the texels are typed in below
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SRC_W-1:0]   data;     // {byte3, byte2, byte1, byte0}
        logic               final_req;
        logic [1:0]         fixed_cnt;
        logic [TEXEL_W-1:0] texel0;
        logic [TEXEL_W-1:0] texel1;
    } unit_row_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [SRC_W-1:0]   s_tdata  = '0;
    logic [MODE_W-1:0]  s_tuser  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TEXEL_W-1:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               m_tlast;

    texel_result_t texel_q[$];  // texels owed by the block, oldest first
    int            mismatches  = 0;
    int            idle_cycles = 0;
    int            rx_hold     = 0;
    bit            tx_gaps_on  = 1'b1;
    bit            rx_gaps_on  = 1'b1;

    // Directed units: extremes of every format, alpha alone, junk in unused
    // bytes, the selector with no format, and the image end on pairs.
    unit_row_t dir_rows [0:24] = '{
        '{MODE_RGBA16, 32'h0000_FFFF, 1'b0, 2'd1, 16'hFFFF, 16'h0000},
        '{MODE_RGBA16, 32'hDEAD_0000, 1'b1, 2'd1, 16'h0000, 16'h0000},
        '{MODE_RGBA16, 32'h0000_0080, 1'b0, 2'd0, 16'h0000, 16'h0000},
        '{MODE_RGBA16, 32'h0000_0100, 1'b0, 2'd1, 16'h8000, 16'h0000},
        '{MODE_RGBA32, 32'hFFFF_FFFF, 1'b1, 2'd1, 16'hFFFF, 16'h0000},
        '{MODE_RGBA32, 32'h0000_0000, 1'b0, 2'd1, 16'h0000, 16'h0000},
        '{MODE_RGBA32, 32'h8000_0000, 1'b0, 2'd1, 16'h8000, 16'h0000},
        '{MODE_RGBA32, 32'h7F07_0707, 1'b0, 2'd0, 16'h0000, 16'h0000},
        '{MODE_IA4,    32'h1234_56FF, 1'b0, 2'd2, 16'hFFFF, 16'hFFFF},
        '{MODE_IA4,    32'hFFFF_FF00, 1'b1, 2'd2, 16'h0000, 16'h0000},
        '{MODE_IA4,    32'h0000_00A5, 1'b0, 2'd0, 16'h0000, 16'h0000},
        '{MODE_IA8,    32'hA5A5_A5FF, 1'b0, 2'd1, 16'hFFFF, 16'h0000},
        '{MODE_IA8,    32'hFFFF_FF00, 1'b0, 2'd1, 16'h0000, 16'h0000},
        '{MODE_IA8,    32'h0000_0037, 1'b1, 2'd0, 16'h0000, 16'h0000},
        '{MODE_IA16,   32'h5A5A_80FF, 1'b0, 2'd1, 16'hFFFF, 16'h0000},
        '{MODE_IA16,   32'hFFFF_7FFF, 1'b0, 2'd1, 16'h7FFF, 16'h0000},
        '{MODE_IA16,   32'hFFFF_0000, 1'b0, 2'd1, 16'h0000, 16'h0000},
        '{MODE_I4,     32'h0F0F_0FFF, 1'b0, 2'd2, 16'hFFFF, 16'hFFFF},
        '{MODE_I4,     32'hFFFF_FF00, 1'b0, 2'd2, 16'h0000, 16'h0000},
        '{MODE_I4,     32'h0000_008F, 1'b0, 2'd0, 16'h0000, 16'h0000},
        '{MODE_I8,     32'hC3C3_C3FF, 1'b0, 2'd1, 16'hFFFF, 16'h0000},
        '{MODE_I8,     32'h0000_007F, 1'b0, 2'd0, 16'h0000, 16'h0000},
        '{MODE_UNUSED, 32'hFFFF_FFFF, 1'b0, 2'd1, 16'h0000, 16'h0000},
        '{MODE_UNUSED, 32'h1357_9BDF, 1'b1, 2'd1, 16'h0000, 16'h0000},
        '{MODE_I4,     32'h0000_003C, 1'b1, 2'd0, 16'h0000, 16'h0000}
    };

    texel_format_converter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24]
        .s_tuser  (s_tuser),   // mode [2:0]
        .s_tlast  (s_tlast),   // final_req
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // texel [15:0]
        .m_tuser  (m_tuser),   // last_of_unit [0]
        .m_tlast  (m_tlast)    // image_end
    );

    always #6 aclk = ~aclk;

    // Gap length: mostly none, often a few cycles, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Grey texel: the 5-bit intensity lands in red, green and blue alike
    function automatic logic [TEXEL_W-1:0] grey_texel(input logic [4:0] level, input logic alpha);
        return {alpha, level, level, level};
    endfunction

    // 4-bit intensity: widen by repeating the top bit, alpha is that top bit
    function automatic logic [TEXEL_W-1:0] nibble_texel(input logic [3:0] nib);
        return grey_texel({nib, nib[3]}, nib[3]);
    endfunction

    // The image end rides only on the last texel of a unit
    task automatic owe_texel(input logic [TEXEL_W-1:0] texel, input logic last, input logic fin);
        texel_q.push_back({texel, last, last & fin});
    endtask

    // Work out the texels one source unit must give and queue them
    task automatic convert_unit(input logic [MODE_W-1:0] mode, input logic [SRC_W-1:0] data,
                                input logic fin);
        logic [7:0]  b0, b1, b2, b3;
        logic [15:0] pix;
        b0  = data[7:0];
        b1  = data[15:8];
        b2  = data[23:16];
        b3  = data[31:24];
        pix = {b0, b1};
        case (mode)
            MODE_RGBA16: owe_texel({pix[0], pix[5:1], pix[10:6], pix[15:11]}, 1'b1, fin);
            MODE_RGBA32: owe_texel({b3[7], b2[7:3], b1[7:3], b0[7:3]}, 1'b1, fin);
            MODE_IA4: begin
                owe_texel(grey_texel({b0[7:5], b0[7:6]}, b0[4]), 1'b0, fin);
                owe_texel(grey_texel({b0[3:1], b0[3:2]}, b0[0]), 1'b1, fin);
            end
            MODE_IA8:  owe_texel(grey_texel({b0[7:4], b0[7]}, b0[3]), 1'b1, fin);
            MODE_IA16: owe_texel(grey_texel(b0[7:3], b1[7]), 1'b1, fin);
            MODE_I4: begin
                owe_texel(nibble_texel(b0[7:4]), 1'b0, fin);
                owe_texel(nibble_texel(b0[3:0]), 1'b1, fin);
            end
            MODE_I8:   owe_texel(grey_texel(b0[7:3], b0[7]), 1'b1, fin);
            default:   owe_texel('0, 1'b1, fin);
        endcase
    endtask

    // Offer one unit, hold it until the slave side takes it, then queue the
    // texels it owes and maybe idle. Entered and left at a rising edge.
    task automatic send_unit(input unit_row_t row);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= row.data;
        s_tuser  <= row.mode;
        s_tlast  <= row.final_req;
        do @(posedge aclk); while (!s_tready);
        if (row.fixed_cnt == 2'd0) begin
            convert_unit(row.mode, row.data, row.final_req);
        end else if (row.fixed_cnt == 2'd1) begin
            owe_texel(row.texel0, 1'b1, row.final_req);
        end else begin
            owe_texel(row.texel0, 1'b0, row.final_req);
            owe_texel(row.texel1, 1'b1, row.final_req);
        end
        gap = tx_gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            // drop valid and scramble the payload while idle
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            s_tuser  <= $urandom_range(0, 7);
            s_tlast  <= $urandom_range(0, 1);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the source until every owed texel has come out; the wait always
    // passes a rising edge so the next unit is driven in a later time step
    task automatic drain_texels();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (texel_q.size() != 0);
    endtask

    // Master side: check each texel taken, then decide on the next stall
    always @(posedge aclk) begin : texel_check
        texel_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (texel_q.size() == 0) begin
                    $error("unexpected texel %h", m_tdata);
                    mismatches++;
                end else begin
                    want = texel_q.pop_front();
                    if (m_tdata !== want.texel) begin
                        $error("texel: expected %h, got %h", want.texel, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.last_of_unit) begin
                        $error("last_of_unit: expected %b, got %b",
                               want.last_of_unit, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tlast !== want.image_end) begin
                        $error("image_end: expected %b, got %b", want.image_end, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                rx_hold  = rx_gaps_on ? idle_len() : 0;
                m_tready <= (rx_hold == 0);
                if (rx_hold > 0) rx_hold--;
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        unit_row_t row;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_rows[k]) send_unit(dir_rows[k]);
        drain_texels();

        // random units in phases: both sides idling, none, sender only, receiver only
        for (int n = 0; n < RANDOM_UNITS; n++) begin
            tx_gaps_on = ((n / 150) % 4) inside {0, 2};
            rx_gaps_on = ((n / 150) % 4) inside {0, 3};
            if (n == RANDOM_UNITS / 2) drain_texels();
            row.mode      = ($urandom_range(0, 15) == 0) ? MODE_UNUSED
                                                         : MODE_W'($urandom_range(0, 6));
            row.data      = $urandom();
            row.final_req = ($urandom_range(0, 9) == 0);
            row.fixed_cnt = 2'd0;
            row.texel0    = '0;
            row.texel1    = '0;
            send_unit(row);
        end

        // wait for the last texels, then watch for strays
        drain_texels();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tfc_pkg.sv
rtl/tfc_front.sv
rtl/tfc_fifo.sv
rtl/tfc_back.sv
rtl/texel_format_converter_core.sv
rtl/tfc_checker.sv
test/texel_format_converter_core_tb.sv
